// ----- hdl/tcw_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared geometry, codes and control types for the text console writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

  localparam int ROWS       = 25;
  localparam int COLS       = 80;
  localparam int CELL_COUNT = ROWS * COLS;

  localparam int ROW_W  = $clog2(ROWS);
  localparam int COL_W  = $clog2(COLS);
  localparam int ADDR_W = $clog2(CELL_COUNT);
  localparam int SCAN_W = $clog2(CELL_COUNT + 1);
  localparam int SUM_W  = $clog2(CELL_COUNT + COLS + 1);

  localparam logic [1:0] FUNC_PUT   = 2'd0;
  localparam logic [1:0] FUNC_READ  = 2'd1;
  localparam logic [1:0] FUNC_CLEAR = 2'd2;

  localparam logic [7:0]  NEWLINE_CODE = 8'h0a;
  localparam logic [7:0]  SPACE_CODE   = 8'h20;
  localparam logic [7:0]  ATTR_RESET   = 8'h07;
  localparam logic [15:0] RESET_BLANK  = 16'h0720;

  typedef struct packed {
    logic load_item;
    logic put_write;
    logic col_step;
    logic line_feed;
    logic read_issue;
    logic scan_clear;
    logic scroll_run;
    logic fill_run;
    logic fill_init;
    logic set_scrolled;
    logic load_result;
  } cmd_t;

  typedef struct packed {
    logic [1:0] func;
    logic       newline;
    logic       col_last;
    logic       last_row;
    logic       fill_end;
    logic       scroll_end;
  } stat_t;

endpackage

// ----- hdl/tcw_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_datapath
// Cell memory, cursor, attribute register, item capture, scan counter and
// result registers.
// ----------------------------------------------------------------------------
module tcw_datapath import tcw_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        cmd,
  output stat_t       stat,
  input  logic [1:0]  func,
  input  logic [7:0]  char_code,
  input  logic [4:0]  read_row,
  input  logic [6:0]  read_col,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_data,
  output logic [4:0]  cursor_row_out,
  output logic [6:0]  cursor_col_out,
  output logic [10:0] cursor_offset,
  output logic [15:0] cell_data,
  output logic        scrolled
);

  localparam logic [ADDR_W-1:0] COLS_A = ADDR_W'(COLS);

  logic [15:0]       mem [CELL_COUNT];
  logic [15:0]       rd_data;
  logic [ROW_W-1:0]  row;
  logic [COL_W-1:0]  col;
  logic [7:0]        attr;
  logic [1:0]        func_q;
  logic [7:0]        char_q;
  logic [4:0]        rrow_q;
  logic [6:0]        rcol_q;
  logic [SCAN_W-1:0] scan_cnt;
  logic              copy_valid;
  logic              scrolled_q;

  logic [ADDR_W-1:0] cursor_pos;
  logic [ADDR_W-1:0] item_addr;
  logic              read_in_range;
  logic [SUM_W-1:0]  scroll_src;
  logic              src_ok;
  logic [15:0]       blank;
  logic              we;
  logic [ADDR_W-1:0] wa;
  logic [15:0]       wd;
  logic              re;
  logic [ADDR_W-1:0] ra;

  assign cursor_pos    = ADDR_W'(ADDR_W'(row) * COLS_A + ADDR_W'(col));
  assign item_addr     = ADDR_W'(ADDR_W'(rrow_q) * COLS_A + ADDR_W'(rcol_q));
  assign read_in_range = (int'(rrow_q) < ROWS) && (int'(rcol_q) < COLS);
  assign scroll_src    = SUM_W'(scan_cnt) + SUM_W'(COLS);
  assign src_ok        = scroll_src < SUM_W'(CELL_COUNT);
  assign blank         = cmd.fill_init ? RESET_BLANK : {attr, SPACE_CODE};

  always_comb begin
    we = 1'b0;
    wa = '0;
    wd = '0;
    priority if (cmd.put_write) begin
      we = 1'b1;
      wa = cursor_pos;
      wd = {attr, char_q};
    end else if (cmd.fill_run) begin
      we = 1'b1;
      wa = ADDR_W'(scan_cnt);
      wd = blank;
    end else if (cmd.scroll_run && (scan_cnt != '0)) begin
      we = 1'b1;
      wa = ADDR_W'(scan_cnt - 1'b1);
      wd = copy_valid ? rd_data : blank;
    end
  end

  assign re = cmd.read_issue || (cmd.scroll_run && src_ok);
  assign ra = cmd.scroll_run ? ADDR_W'(scroll_src) : item_addr;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (re) begin
      rd_data <= mem[ra];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row        <= '0;
      col        <= '0;
      attr       <= ATTR_RESET;
      scan_cnt   <= '0;
      copy_valid <= 1'b0;
      scrolled_q <= 1'b0;
    end else begin
      if (cfg_we) begin
        attr <= cfg_data;
      end
      if (cmd.line_feed) begin
        col <= '0;
        if (row != ROW_W'(ROWS - 1)) begin
          row <= row + 1'b1;
        end
      end else if (cmd.col_step) begin
        col <= col + 1'b1;
      end
      if (cmd.scan_clear) begin
        scan_cnt <= '0;
      end else if (cmd.scroll_run || cmd.fill_run) begin
        scan_cnt <= scan_cnt + 1'b1;
      end
      if (cmd.scroll_run) begin
        copy_valid <= src_ok;
      end
      if (cmd.load_item) begin
        scrolled_q <= 1'b0;
      end else if (cmd.set_scrolled) begin
        scrolled_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      func_q <= func;
      char_q <= char_code;
      rrow_q <= read_row;
      rcol_q <= read_col;
    end
    if (cmd.load_result) begin
      cursor_row_out <= 5'(row);
      cursor_col_out <= 7'(col);
      cursor_offset  <= 11'(cursor_pos);
      cell_data      <= ((func_q == FUNC_READ) && read_in_range) ? rd_data : '0;
      scrolled       <= scrolled_q;
    end
  end

  assign stat.func       = func_q;
  assign stat.newline    = (char_q == NEWLINE_CODE);
  assign stat.col_last   = (col == COL_W'(COLS - 1));
  assign stat.last_row   = (row == ROW_W'(ROWS - 1));
  assign stat.fill_end   = (scan_cnt == SCAN_W'(CELL_COUNT - 1));
  assign stat.scroll_end = (scan_cnt == SCAN_W'(CELL_COUNT));

endmodule

// ----- hdl/tcw_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_ctrl
// Controller: sequences put, read, clear and scroll passes and owns the
// input and output handshakes.
// ----------------------------------------------------------------------------
module tcw_ctrl import tcw_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_stall,
  output logic  out_valid,
  input  logic  out_stall,
  input  stat_t stat,
  output cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_DECODE,
    S_SCROLL,
    S_FILL,
    S_READ,
    S_FINISH
  } state_t;

  state_t state;
  state_t state_next;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_INIT: begin
        cmd.fill_run  = 1'b1;
        cmd.fill_init = 1'b1;
        if (stat.fill_end) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_next    = S_DECODE;
        end
      end
      S_DECODE: begin
        state_next = S_FINISH;
        unique case (stat.func)
          FUNC_PUT: begin
            if (!stat.newline) begin
              cmd.put_write = 1'b1;
            end
            if (stat.newline || stat.col_last) begin
              cmd.line_feed = 1'b1;
              if (stat.last_row) begin
                cmd.scan_clear   = 1'b1;
                cmd.set_scrolled = 1'b1;
                state_next       = S_SCROLL;
              end
            end else begin
              cmd.col_step = 1'b1;
            end
          end
          FUNC_READ: begin
            cmd.read_issue = 1'b1;
            state_next     = S_READ;
          end
          FUNC_CLEAR: begin
            cmd.scan_clear = 1'b1;
            state_next     = S_FILL;
          end
          default: begin
            state_next = S_FINISH;
          end
        endcase
      end
      S_SCROLL: begin
        cmd.scroll_run = 1'b1;
        if (stat.scroll_end) begin
          state_next = S_FINISH;
        end
      end
      S_FILL: begin
        cmd.fill_run = 1'b1;
        if (stat.fill_end) begin
          state_next = S_FINISH;
        end
      end
      S_READ: begin
        state_next = S_FINISH;
      end
      S_FINISH: begin
        if (!out_valid || !out_stall) begin
          cmd.load_result = 1'b1;
          state_next      = S_IDLE;
        end
      end
      default: begin
        state_next = S_INIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_result) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ----- hdl/text_console_char_writer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_char_writer
// Text-mode console: cell memory with cursor, put, read, clear and scroll.
// ----------------------------------------------------------------------------
// After reset the block sweeps all ROWS*COLS cells (2000 at 25 by 80) of the
// cell memory to blanks, one cell a cycle, and holds in_stall high meanwhile;
// attribute writes are taken throughout. One transaction at a time is worked
// on. A read also passes through the S_READ state, as the cell memory has a
// registered read port. A clear or a scroll sweeps the whole cell memory, at
// most one memory write per cycle through the single write port. The result
// register lets a new transaction be accepted while the previous result is
// still waiting.
module text_console_char_writer import tcw_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  func,
  input  logic [7:0]  char_code,
  input  logic [4:0]  read_row,
  input  logic [6:0]  read_col,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [4:0]  cursor_row_out,
  output logic [6:0]  cursor_col_out,
  output logic [10:0] cursor_offset,
  output logic [15:0] cell_data,
  output logic        scrolled,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data
);

  cmd_t  cmd;
  stat_t stat;

  assign cfg_ready = 1'b1;

  tcw_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  tcw_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .func           (func),
    .char_code      (char_code),
    .read_row       (read_row),
    .read_col       (read_col),
    .cfg_we         (cfg_valid && cfg_ready),
    .cfg_data       (cfg_data),
    .cursor_row_out (cursor_row_out),
    .cursor_col_out (cursor_col_out),
    .cursor_offset  (cursor_offset),
    .cell_data      (cell_data),
    .scrolled       (scrolled)
  );

endmodule

// ----- hdl/tcw_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_port_checker
// Port-level checks for the text console writer, bound to the top level.
// ----------------------------------------------------------------------------
module tcw_port_checker import tcw_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [4:0]  cursor_row_out,
  input logic [6:0]  cursor_col_out,
  input logic [10:0] cursor_offset,
  input logic [15:0] cell_data,
  input logic        scrolled
);

  // one transaction in flight at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input accepted while previous transaction in progress");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(cursor_offset)
      && $stable(cell_data) && $stable(scrolled)))
    else $error("stalled result changed");

  a_col_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (int'(cursor_col_out) < COLS))
    else $error("cursor column out of range");

  a_scroll_cursor: assert property (@(posedge clk) disable iff (rst)
    (out_valid && scrolled) |-> ((cursor_row_out == 5'(ROWS - 1))
      && (cursor_col_out == '0)))
    else $error("scroll left cursor off the start of the last row");

endmodule

bind text_console_char_writer tcw_port_checker u_tcw_checker (.*);

// ----- tb/sv/tcw_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_checker
// Console scoreboard: follows the command, result and attribute channels,
// keeps its own copy of the cell store, cursor and attribute, and compares
// every accepted result with the oldest predicted cursor report.
// ----------------------------------------------------------------------------
module tcw_checker import tcw_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  func,
  input  logic [7:0]  char_code,
  input  logic [4:0]  read_row,
  input  logic [6:0]  read_col,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [4:0]  cursor_row_out,
  input  logic [6:0]  cursor_col_out,
  input  logic [10:0] cursor_offset,
  input  logic [15:0] cell_data,
  input  logic        scrolled,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [7:0]  cfg_data,
  output int          fail_count,
  output int          reports_outstanding
);

  typedef struct packed {
    logic [4:0]  row;
    logic [6:0]  col;
    logic [10:0] offset;
    logic [15:0] cell_word;
    logic        did_scroll;
  } cursor_report_t;

  logic [15:0]    screen_copy [CELL_COUNT];
  int             cur_row;
  int             cur_col;
  logic [7:0]     attr;
  cursor_report_t cursor_reports [$];

  initial begin
    fail_count          = 0;
    reports_outstanding = 0;
  end

  function automatic logic line_feed();
    logic wrapped;
    wrapped = 1'b0;
    if (cur_row >= ROWS - 1) begin
      for (int i = 0; i + COLS < CELL_COUNT; i++) screen_copy[i] = screen_copy[i + COLS];
      for (int i = CELL_COUNT - COLS; i < CELL_COUNT; i++) screen_copy[i] = {attr, SPACE_CODE};
      cur_row = ROWS - 1;
      wrapped = 1'b1;
    end else begin
      cur_row++;
    end
    cur_col = 0;
    return wrapped;
  endfunction

  function automatic cursor_report_t apply_console_op(logic [1:0] f, logic [7:0] ch,
                                                       logic [4:0] rr, logic [6:0] rc);
    cursor_report_t rep;
    int             pos;
    rep = '0;
    case (f)
      FUNC_PUT: begin
        if (ch == NEWLINE_CODE) begin
          rep.did_scroll = line_feed();
        end else begin
          pos = cur_row * COLS + cur_col;
          if (pos < CELL_COUNT) screen_copy[pos] = {attr, ch};
          cur_col++;
          if (cur_col >= COLS) rep.did_scroll = line_feed();
        end
      end
      FUNC_READ: begin
        if (rr < ROWS && rc < COLS) rep.cell_word = screen_copy[rr * COLS + rc];
      end
      FUNC_CLEAR: begin
        for (int i = 0; i < CELL_COUNT; i++) screen_copy[i] = {attr, SPACE_CODE};
      end
      default: ;
    endcase
    rep.row    = cur_row[4:0];
    rep.col    = cur_col[6:0];
    rep.offset = 11'((cur_row * COLS + cur_col) & 32'h7ff);
    return rep;
  endfunction

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected 0x%0h actual 0x%0h", $time, name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    cursor_report_t want;
    if (rst) begin
      for (int i = 0; i < CELL_COUNT; i++) screen_copy[i] = RESET_BLANK;
      cur_row = 0;
      cur_col = 0;
      attr    = ATTR_RESET;
      cursor_reports.delete();
    end else begin
      if (cfg_valid && cfg_ready) attr = cfg_data;
      if (in_valid && !in_stall)
        cursor_reports.push_back(apply_console_op(func, char_code, read_row, read_col));
      if (out_valid && !out_stall) begin
        if (cursor_reports.size() == 0) begin
          $display("%0t: result with no transaction pending, actual row %0d col %0d cell 0x%0h",
                   $time, cursor_row_out, cursor_col_out, cell_data);
          fail_count++;
        end else begin
          want = cursor_reports.pop_front();
          check_field("cursor_row_out", 32'(want.row), 32'(cursor_row_out));
          check_field("cursor_col_out", 32'(want.col), 32'(cursor_col_out));
          check_field("cursor_offset", 32'(want.offset), 32'(cursor_offset));
          check_field("cell_data", 32'(want.cell_word), 32'(cell_data));
          check_field("scrolled", 32'(want.did_scroll), 32'(scrolled));
        end
      end
    end
    reports_outstanding = cursor_reports.size();
  end

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Console writer testbench: drives directed and random put, newline, read,
// clear and unused commands under several text attributes, with random
// gaps and output back-pressure; the checker scores every result.
// ----------------------------------------------------------------------------
module tb_top import tcw_pkg::*;;

  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam int         CYCLE_LIMIT = 4_000_000;
  localparam int         PHASE_ITEMS = 130;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  logic [1:0]  func      = '0;
  logic [7:0]  char_code = '0;
  logic [4:0]  read_row  = '0;
  logic [6:0]  read_col  = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [4:0]  cursor_row_out;
  logic [6:0]  cursor_col_out;
  logic [10:0] cursor_offset;
  logic [15:0] cell_data;
  logic        scrolled;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_data  = '0;

  int fail_count;
  int reports_outstanding;
  int cycle_count = 0;
  bit burst_en    = 1'b1;

  text_console_char_writer i_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .func           (func),
    .char_code      (char_code),
    .read_row       (read_row),
    .read_col       (read_col),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .cursor_row_out (cursor_row_out),
    .cursor_col_out (cursor_col_out),
    .cursor_offset  (cursor_offset),
    .cell_data      (cell_data),
    .scrolled       (scrolled),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data)
  );

  tcw_checker i_checker (
    .clk                 (clk),
    .rst                 (rst),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .func                (func),
    .char_code           (char_code),
    .read_row            (read_row),
    .read_col            (read_col),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .cursor_row_out      (cursor_row_out),
    .cursor_col_out      (cursor_col_out),
    .cursor_offset       (cursor_offset),
    .cell_data           (cell_data),
    .scrolled            (scrolled),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_data            (cfg_data),
    .fail_count          (fail_count),
    .reports_outstanding (reports_outstanding)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // result back-pressure in bursts
  initial begin
    int hold;
    hold = 0;
    forever begin
      @(negedge clk);
      if (!burst_en) begin
        out_stall <= 1'b0;
      end else if (hold == 0) begin
        if (!out_stall && $urandom_range(0, 2) == 0) begin
          out_stall <= 1'b1;
          hold = $urandom_range(0, 5);
        end else begin
          out_stall <= 1'b0;
          hold = $urandom_range(1, 8);
        end
      end else begin
        hold--;
      end
    end
  end

  task automatic send_console_op(input logic [1:0] f, input logic [7:0] ch,
                                 input logic [4:0] rr, input logic [6:0] rc);
    if (burst_en && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    in_valid  <= 1'b1;
    func      <= f;
    char_code <= ch;
    read_row  <= rr;
    read_col  <= rc;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic write_attribute(input logic [7:0] value);
    while (reports_outstanding != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_random_phase(input int count);
    int          pick;
    logic [1:0]  f;
    logic [7:0]  ch;
    logic [4:0]  rr;
    logic [6:0]  rc;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      ch   = 8'($urandom);
      rr   = 5'($urandom);
      rc   = 7'($urandom);
      if (pick < 70) begin
        f = FUNC_PUT;
      end else if (pick < 80) begin
        f  = FUNC_PUT;
        ch = NEWLINE_CODE;
      end else if (pick < 92) begin
        f = FUNC_READ;
        if ($urandom_range(0, 4) != 0) begin
          rr = ($urandom_range(0, 1) != 0) ? 5'($urandom_range(ROWS - 5, ROWS - 1))
                                           : 5'($urandom_range(0, ROWS - 1));
          rc = 7'($urandom_range(0, COLS - 1));
        end
      end else if (pick < 95) begin
        f = FUNC_UNUSED;
      end else begin
        f = FUNC_CLEAR;
      end
      send_console_op(f, ch, rr, rc);
    end
    in_valid <= 1'b0;
  endtask

  initial begin
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send_console_op(FUNC_READ, 8'h00, 5'd0, 7'd0);
    send_console_op(FUNC_READ, 8'hff, 5'(ROWS - 1), 7'(COLS - 1));
    send_console_op(FUNC_READ, 8'h00, 5'(ROWS), 7'd0);
    send_console_op(FUNC_READ, 8'h00, 5'd0, 7'(COLS));
    send_console_op(FUNC_READ, 8'h00, 5'h1f, 7'h7f);
    send_console_op(FUNC_PUT, 8'h41, 5'h1f, 7'h7f);
    send_console_op(FUNC_READ, 8'h00, 5'd0, 7'd0);
    in_valid <= 1'b0;
    write_attribute(8'hff);
    send_console_op(FUNC_PUT, 8'h00, 5'd0, 7'd0);
    send_console_op(FUNC_PUT, 8'hff, 5'd0, 7'd0);
    send_console_op(FUNC_PUT, NEWLINE_CODE, 5'd0, 7'd0);
    send_console_op(FUNC_UNUSED, 8'hff, 5'h1f, 7'h7f);
    send_console_op(FUNC_READ, 8'h00, 5'd0, 7'd1);
    send_console_op(FUNC_READ, 8'h00, 5'd0, 7'd2);
    send_console_op(FUNC_CLEAR, 8'h00, 5'd0, 7'd0);
    send_console_op(FUNC_READ, 8'h00, 5'd0, 7'd0);
    in_valid <= 1'b0;
    write_attribute(8'h00);
    send_console_op(FUNC_PUT, SPACE_CODE, 5'd0, 7'd0);
    send_console_op(FUNC_READ, 8'h00, 5'd1, 7'd0);
    send_console_op(FUNC_READ, 8'h00, 5'(ROWS - 1), 7'd0);
    in_valid <= 1'b0;

    for (int p = 0; p < 5; p++) begin
      case (p)
        0:       write_attribute(8'h00);
        1:       write_attribute(8'hff);
        4:       write_attribute(8'h1e);
        default: write_attribute(8'($urandom));
      endcase
      if (p == 4) burst_en = 1'b0;
      run_random_phase(PHASE_ITEMS);
    end

    @(negedge clk);
    while (reports_outstanding != 0) @(negedge clk);
    repeat (50) @(negedge clk);
    if (fail_count == 0 && reports_outstanding == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ----- text_console_char_writer.f -----
hdl/tcw_pkg.sv
hdl/tcw_datapath.sv
hdl/tcw_ctrl.sv
hdl/text_console_char_writer.sv
hdl/tcw_checker.sv
tb/sv/tcw_checker.sv
tb/sv/tb_top.sv
